@@ rtl/bts_pkg.sv @@
// ----------------------------------------------------------------------------
// bts_pkg
// Shared widths, codes and controller/datapath types of the texture sampler.
// ----------------------------------------------------------------------------
`default_nettype none

package bts_pkg;

    localparam int TEXEL_ADDR_W = 16;
    localparam int CH_W         = 8;
    localparam int TEXEL_W      = 3 * CH_W;
    localparam int COORD_W      = 16;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_TEX_WIDTH       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_HEIGHT      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXTURE_PRESENT = 2'd2;

    localparam logic [TEXEL_W-1:0] CHECK_COLOR = 24'hFF55FF;
    localparam logic [TEXEL_W-1:0] CHECK_BLACK = 24'h000000;

    typedef enum logic {
        OP_LOAD   = 1'b0,
        OP_SAMPLE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        TAP_00 = 2'd0,
        TAP_01 = 2'd1,
        TAP_10 = 2'd2,
        TAP_11 = 2'd3
    } t_tap;

    typedef enum logic {
        RES_FILTER  = 1'b0,
        RES_CHECKER = 1'b1
    } t_res_src;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ROW,
        S_RD0,
        S_RD1,
        S_RD2,
        S_RD3,
        S_BLX,
        S_BLY,
        S_CHK
    } t_state;

    typedef struct packed {
        logic     mem_we;    // write the load request into the store
        logic     split_en;  // latch coordinates and axis split
        logic     row_en;    // latch row base addresses
        logic     rd_en;
        t_tap     rd_sel;
        logic     cap_en;
        t_tap     cap_sel;
        logic     blx_en;    // horizontal blend of both rows
        logic     push;      // load the output register
        t_res_src push_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic tex_present;
    } t_dp_status;

endpackage

`default_nettype wire

@@ rtl/bts_ifs.sv @@
// ----------------------------------------------------------------------------
// bts channel interfaces
// Request, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface bts_req_if;
    logic                               valid;
    logic                               ready;
    logic                               operation;
    logic [bts_pkg::TEXEL_ADDR_W-1:0]   texel_address;
    logic [bts_pkg::CH_W-1:0]           load_red;
    logic [bts_pkg::CH_W-1:0]           load_green;
    logic [bts_pkg::CH_W-1:0]           load_blue;
    logic [bts_pkg::COORD_W-1:0]        coord_u;
    logic [bts_pkg::COORD_W-1:0]        coord_v;

    modport source (
        output valid, operation, texel_address, load_red, load_green, load_blue,
               coord_u, coord_v,
        input  ready
    );
    modport sink (
        input  valid, operation, texel_address, load_red, load_green, load_blue,
               coord_u, coord_v,
        output ready
    );
endinterface

interface bts_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [bts_pkg::CH_W-1:0]   out_red;
    logic [bts_pkg::CH_W-1:0]   out_green;
    logic [bts_pkg::CH_W-1:0]   out_blue;

    modport source (
        output valid, out_red, out_green, out_blue,
        input  ready
    );
    modport sink (
        input  valid, out_red, out_green, out_blue,
        output ready
    );
endinterface

interface bts_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [bts_pkg::CFG_IDX_W-1:0]      index;
    logic [bts_pkg::CFG_DATA_W-1:0]     data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/bts_ctrl.sv @@
// ----------------------------------------------------------------------------
// bts_ctrl
// Sequencer: accepts requests, steps the datapath through the four texel
// reads and two blend passes, and owns the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module bts_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_req_valid,
    input  wire logic                i_req_op,
    input  wire logic                i_out_ready,
    input  wire bts_pkg::t_dp_status i_status,
    output logic                     o_req_ready,
    output logic                     o_out_valid,
    output bts_pkg::t_dp_cmd         o_cmd
);
    import bts_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   accept;
    logic   out_free;

    assign accept   = i_req_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || i_out_ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && (i_req_op == OP_SAMPLE)) begin
                    n_state = i_status.tex_present ? S_ROW : S_CHK;
                end
            end
            S_ROW: n_state = S_RD0;
            S_RD0: n_state = S_RD1;
            S_RD1: n_state = S_RD2;
            S_RD2: n_state = S_RD3;
            S_RD3: n_state = S_BLX;
            S_BLX: n_state = S_BLY;
            S_BLY: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_CHK: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd          = '0;
        o_cmd.rd_sel   = TAP_00;
        o_cmd.cap_sel  = TAP_00;
        o_cmd.push_sel = RES_FILTER;
        o_req_ready    = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_req_ready    = 1'b1;
                o_cmd.mem_we   = accept && (i_req_op == OP_LOAD);
                o_cmd.split_en = accept && (i_req_op == OP_SAMPLE);
            end
            S_ROW: o_cmd.row_en = 1'b1;
            S_RD0: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = TAP_00;
            end
            S_RD1: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_sel  = TAP_01;
                o_cmd.cap_en  = 1'b1;
                o_cmd.cap_sel = TAP_00;
            end
            S_RD2: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_sel  = TAP_10;
                o_cmd.cap_en  = 1'b1;
                o_cmd.cap_sel = TAP_01;
            end
            S_RD3: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_sel  = TAP_11;
                o_cmd.cap_en  = 1'b1;
                o_cmd.cap_sel = TAP_10;
            end
            S_BLX: o_cmd.blx_en = 1'b1;
            S_BLY: begin
                o_cmd.push     = out_free;
                o_cmd.push_sel = RES_FILTER;
            end
            S_CHK: begin
                o_cmd.push     = out_free;
                o_cmd.push_sel = RES_CHECKER;
            end
            default: o_req_ready = 1'b0;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.push) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

@@ rtl/bts_dpath.sv @@
// ----------------------------------------------------------------------------
// bts_dpath
// Configuration registers, single-port texel store, coordinate split,
// address generation, two-pass bilinear blend and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bts_dpath #(
    parameter int MAX_DIM          = 256,
    parameter int COORD_FRAC_BITS  = 16,
    parameter int WEIGHT_FRAC_BITS = 8
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [bts_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [bts_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  wire bts_pkg::t_dp_cmd                    i_cmd,
    output bts_pkg::t_dp_status                      o_status,
    input  wire logic [bts_pkg::TEXEL_ADDR_W-1:0]    i_texel_address,
    input  wire logic [bts_pkg::CH_W-1:0]            i_load_red,
    input  wire logic [bts_pkg::CH_W-1:0]            i_load_green,
    input  wire logic [bts_pkg::CH_W-1:0]            i_load_blue,
    input  wire logic [bts_pkg::COORD_W-1:0]         i_coord_u,
    input  wire logic [bts_pkg::COORD_W-1:0]         i_coord_v,
    output logic [bts_pkg::CH_W-1:0]                 o_out_red,
    output logic [bts_pkg::CH_W-1:0]                 o_out_green,
    output logic [bts_pkg::CH_W-1:0]                 o_out_blue
);
    import bts_pkg::*;

    localparam int DEPTH    = MAX_DIM * MAX_DIM;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int DIM_W    = $clog2(MAX_DIM);
    localparam int SIZE_W   = $clog2(MAX_DIM + 1);
    localparam int CFB      = COORD_FRAC_BITS;
    localparam int WFB      = WEIGHT_FRAC_BITS;
    localparam int POS_W    = (SIZE_W + COORD_W > CFB + 1) ? SIZE_W + COORD_W : CFB + 1;
    localparam int RS       = (CFB > WFB) ? CFB - WFB : 0;
    localparam int LS       = (WFB > CFB) ? WFB - CFB : 0;
    localparam int FW_W     = CFB + LS;
    localparam int ACC_W    = CH_W + WFB + 2;
    localparam int CHK_BIT  = CFB - 3;
    localparam logic [COORD_W-1:0] COORD_MASK = COORD_W'((33'd1 << CFB) - 33'd1);
    localparam logic [WFB:0]       WEIGHT_ONE = (WFB + 1)'(1) << WFB;

    typedef struct packed {
        logic [DIM_W-1:0] lo;
        logic [DIM_W-1:0] hi;
        logic [WFB-1:0]   f;
    } t_axis;

    function automatic logic [SIZE_W-1:0] clamp_dim(input logic [CFG_DATA_W-1:0] d);
        logic [SIZE_W-1:0] r;
        if (d == '0) begin
            r = SIZE_W'(1);
        end else if (32'(d) > MAX_DIM) begin
            r = SIZE_W'(MAX_DIM);
        end else begin
            r = SIZE_W'(d);
        end
        return r;
    endfunction

    // size*coord gives the texel index and fraction; far neighbour wraps
    function automatic t_axis split_axis(input logic [SIZE_W-1:0] size,
                                         input logic [COORD_W-1:0] coord);
        logic [POS_W-1:0]  pos;
        logic [POS_W-1:0]  lo_raw;
        logic [SIZE_W-1:0] lo;
        logic [SIZE_W-1:0] nxt;
        logic [FW_W-1:0]   fw;
        t_axis             r;
        pos    = POS_W'(size) * POS_W'(coord & COORD_MASK);
        lo_raw = pos >> CFB;
        if (lo_raw >= POS_W'(size)) begin
            lo = size - SIZE_W'(1);
        end else begin
            lo = SIZE_W'(lo_raw);
        end
        nxt = lo + SIZE_W'(1);
        if (nxt == size) begin
            nxt = '0;
        end
        fw   = FW_W'(pos[CFB-1:0]) << LS;
        r.lo = DIM_W'(lo);
        r.hi = DIM_W'(nxt);
        r.f  = WFB'(fw >> RS);
        return r;
    endfunction

    function automatic logic [CH_W-1:0] blend_ch(input logic [CH_W-1:0] a,
                                                 input logic [CH_W-1:0] b,
                                                 input logic [WFB-1:0]  f);
        logic [ACC_W-1:0] acc;
        acc = ACC_W'(a) * ACC_W'(WEIGHT_ONE - (WFB + 1)'(f)) + ACC_W'(b) * ACC_W'(f);
        return acc[WFB+CH_W-1:WFB];
    endfunction

    function automatic logic [TEXEL_W-1:0] blend_texel(input logic [TEXEL_W-1:0] a,
                                                       input logic [TEXEL_W-1:0] b,
                                                       input logic [WFB-1:0]     f);
        logic [TEXEL_W-1:0] r;
        r = '0;
        for (int c = 0; c < 3; c++) begin
            r[c*CH_W +: CH_W] = blend_ch(a[c*CH_W +: CH_W], b[c*CH_W +: CH_W], f);
        end
        return r;
    endfunction

    // configuration
    logic [SIZE_W-1:0] r_width;
    logic [SIZE_W-1:0] r_height;
    logic              r_present;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= SIZE_W'(1);
            r_height  <= SIZE_W'(1);
            r_present <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TEX_WIDTH:       r_width   <= clamp_dim(i_cfg_data);
                CFG_TEX_HEIGHT:      r_height  <= clamp_dim(i_cfg_data);
                CFG_TEXTURE_PRESENT: r_present <= i_cfg_data[0];
                default:             r_present <= r_present;
            endcase
        end
    end

    assign o_status.tex_present = r_present;

    // coordinate split, latched at accept
    t_axis              ax_x;
    t_axis              ax_y;
    logic [COORD_W-1:0] r_u;
    logic [COORD_W-1:0] r_v;
    logic [DIM_W-1:0]   r_x0;
    logic [DIM_W-1:0]   r_x1;
    logic [DIM_W-1:0]   r_y0;
    logic [DIM_W-1:0]   r_y1;
    logic [WFB-1:0]     r_fx;
    logic [WFB-1:0]     r_fy;

    assign ax_x = split_axis(r_width, i_coord_u);
    assign ax_y = split_axis(r_height, i_coord_v);

    always_ff @(posedge i_clk) begin
        if (i_cmd.split_en) begin
            r_u  <= i_coord_u;
            r_v  <= i_coord_v;
            r_x0 <= ax_x.lo;
            r_x1 <= ax_x.hi;
            r_fx <= ax_x.f;
            r_y0 <= ax_y.lo;
            r_y1 <= ax_y.hi;
            r_fy <= ax_y.f;
        end
    end

    // row base addresses
    logic [ADDR_W-1:0] r_row0;
    logic [ADDR_W-1:0] r_row1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.row_en) begin
            r_row0 <= ADDR_W'(r_y0) * ADDR_W'(r_width);
            r_row1 <= ADDR_W'(r_y1) * ADDR_W'(r_width);
        end
    end

    // texel store, one port
    logic [TEXEL_W-1:0] mem [DEPTH];
    logic [TEXEL_W-1:0] r_rdata;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ADDR_W-1:0]  mem_addr;
    logic               load_in_range;

    always_comb begin
        case (i_cmd.rd_sel)
            TAP_00:  rd_addr = r_row0 + ADDR_W'(r_x0);
            TAP_01:  rd_addr = r_row0 + ADDR_W'(r_x1);
            TAP_10:  rd_addr = r_row1 + ADDR_W'(r_x0);
            TAP_11:  rd_addr = r_row1 + ADDR_W'(r_x1);
            default: rd_addr = r_row0;
        endcase
    end

    assign load_in_range = (32'(i_texel_address) < DEPTH);
    assign mem_addr      = i_cmd.mem_we ? ADDR_W'(i_texel_address) : rd_addr;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_we) begin
            if (load_in_range) begin
                mem[mem_addr] <= {i_load_red, i_load_green, i_load_blue};
            end
        end else if (i_cmd.rd_en) begin
            r_rdata <= mem[mem_addr];
        end
    end

    // tap holding registers
    logic [TEXEL_W-1:0] r_t00;
    logic [TEXEL_W-1:0] r_t01;
    logic [TEXEL_W-1:0] r_t10;

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_en) begin
            case (i_cmd.cap_sel)
                TAP_00:  r_t00 <= r_rdata;
                TAP_01:  r_t01 <= r_rdata;
                TAP_10:  r_t10 <= r_rdata;
                default: r_t10 <= r_t10;
            endcase
        end
    end

    // blend along x for both rows; far-bottom texel still sits in r_rdata
    logic [TEXEL_W-1:0] r_top;
    logic [TEXEL_W-1:0] r_bot;

    always_ff @(posedge i_clk) begin
        if (i_cmd.blx_en) begin
            r_top <= blend_texel(r_t00, r_t01, r_fx);
            r_bot <= blend_texel(r_t10, r_rdata, r_fx);
        end
    end

    // checkerboard parity: floor(8u)+floor(8v) odd
    logic chk_odd;
    generate
        if (CHK_BIT < COORD_W) begin : g_chk
            assign chk_odd = r_u[CHK_BIT] ^ r_v[CHK_BIT];
        end else begin : g_chk_none
            assign chk_odd = 1'b0;
        end
    endgenerate

    logic [TEXEL_W-1:0] r_out;
    logic [TEXEL_W-1:0] res;

    always_comb begin
        case (i_cmd.push_sel)
            RES_FILTER:  res = blend_texel(r_top, r_bot, r_fy);
            RES_CHECKER: res = chk_odd ? CHECK_COLOR : CHECK_BLACK;
            default:     res = CHECK_BLACK;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out <= res;
        end
    end

    assign o_out_red   = r_out[2*CH_W +: CH_W];
    assign o_out_green = r_out[CH_W +: CH_W];
    assign o_out_blue  = r_out[0 +: CH_W];

endmodule

`default_nettype wire

@@ rtl/bilinear_texture_sampler.sv @@
// ----------------------------------------------------------------------------
// bilinear_texture_sampler
// Load: done in the accept cycle, one texel written into the store, no result.
// Sample with texture: accept and coordinate split, row base addresses, then the
//   four reads of the single-port texel store, one per cycle, x blend and y blend.
// Sample without texture (checkerboard): accept, then the result register load.
// One request in flight: a new request is taken only once the last is done; output stalls delay it.
// Reset (synchronous, active low) clears control and config; store is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module bilinear_texture_sampler #(
    parameter int MAX_DIM          = 256,
    parameter int COORD_FRAC_BITS  = 16,
    parameter int WEIGHT_FRAC_BITS = 8
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    bts_req_if.sink     i_req,
    bts_rsp_if.source   o_rsp,
    bts_cfg_if.sink     i_cfg
);
    import bts_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    assign i_cfg.ready = 1'b1;

    bts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_op    (i_req.operation),
        .i_out_ready (o_rsp.ready),
        .i_status    (status),
        .o_req_ready (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .o_cmd       (cmd)
    );

    bts_dpath #(
        .MAX_DIM          (MAX_DIM),
        .COORD_FRAC_BITS  (COORD_FRAC_BITS),
        .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg.valid),
        .i_cfg_index     (i_cfg.index),
        .i_cfg_data      (i_cfg.data),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_texel_address (i_req.texel_address),
        .i_load_red      (i_req.load_red),
        .i_load_green    (i_req.load_green),
        .i_load_blue     (i_req.load_blue),
        .i_coord_u       (i_req.coord_u),
        .i_coord_v       (i_req.coord_v),
        .o_out_red       (o_rsp.out_red),
        .o_out_green     (o_rsp.out_green),
        .o_out_blue      (o_rsp.out_blue)
    );

    // store writes only come from an accepted load request
    a_we_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.mem_we |-> (i_req.valid && i_req.ready && (i_req.operation == OP_LOAD)))
        else $error("store write without accepted load request");

    // a result never overwrites one that is still waiting
    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.push |-> (!o_rsp.valid || o_rsp.ready))
        else $error("result pushed over pending result");

    a_push_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.push |=> o_rsp.valid)
        else $error("pushed result not presented");

    // no request accepted while the store port is busy with reads
    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.rd_en |-> !i_req.ready)
        else $error("request accepted during texel reads");

endmodule

`default_nettype wire
